>>> rtl/core/scpwm_pkg.sv
package scpwm_pkg;

  localparam int ANGLE_W     = 16;
  localparam int TORQUE_W    = 13;
  localparam int DUTY_W      = 10;
  localparam int NUM_PHASES  = 3;
  localparam int NUM_STAGES  = 5;

  // Torque is unsigned Q1.12; values above 1.0 are clamped to 1.0.
  localparam int                  TORQUE_FRAC = 12;
  localparam logic [TORQUE_W-1:0] TORQUE_FULL = TORQUE_W'(1 << TORQUE_FRAC);

  // Phase angles are kept in thirds of an angle unit, so the 1/3 and 2/3
  // turn offsets are exact. One turn spans three times 2^16 such units.
  localparam int PHASE_W = ANGLE_W + 2;
  localparam int SPAN    = 3 * (1 << ANGLE_W);

  // floor(y / 3) = (y * RECIP3) >> RECIP3_SHIFT, exact for y below 2^16.
  localparam int               RECIP3_W     = 16;
  localparam logic [RECIP3_W-1:0] RECIP3    = 16'd43691;
  localparam int               RECIP3_SHIFT = 17;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic ld_phase;
    logic ld_scale;
    logic ld_index;
    logic ld_read;
    logic ld_duty;
  } stage_ld_t;

endpackage

>>> rtl/core/scpwm_index.sv
module scpwm_index #(
  parameter int TABLE_DEPTH = 244,
  localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic                                       clk,
  input  scpwm_pkg::stage_ld_t                       ld,
  input  logic [scpwm_pkg::ANGLE_W-1:0]              in_field_angle,
  input  logic [scpwm_pkg::TORQUE_W-1:0]             in_torque,
  output logic [scpwm_pkg::NUM_PHASES-1:0][IDX_W-1:0] idx_o,
  output logic [scpwm_pkg::TORQUE_W-1:0]             torque_o
);

  localparam int DEPTH_W = $clog2(TABLE_DEPTH + 1);
  localparam int Y_W     = $clog2(3 * TABLE_DEPTH);
  localparam int NPH     = scpwm_pkg::NUM_PHASES;
  localparam int PH_W    = scpwm_pkg::PHASE_W;
  localparam logic [DEPTH_W-1:0] DEPTH_C = DEPTH_W'(TABLE_DEPTH);

  logic [NPH-1:0][PH_W-1:0]  phase_nxt, phase_r;
  logic [NPH-1:0][Y_W-1:0]   scaled_nxt, scaled_r;
  logic [NPH-1:0][IDX_W-1:0] idx_nxt, idx_r;
  logic [scpwm_pkg::TORQUE_W-1:0] torque1_nxt, torque1_r, torque2_r, torque3_r;

  // Stage 1: three phase angles in thirds of a unit, wrapped to one turn, and the torque clamp.
  always_comb begin
    logic [PH_W-1:0] ang3;
    logic [PH_W:0]   s;
    ang3 = {2'b00, in_field_angle} + {1'b0, in_field_angle, 1'b0};
    for (int k = 0; k < NPH; k++) begin
      s = {1'b0, ang3} + ((PH_W + 1)'(k) << scpwm_pkg::ANGLE_W);
      if (s >= (PH_W + 1)'(scpwm_pkg::SPAN)) begin
        phase_nxt[k] = PH_W'(s - (PH_W + 1)'(scpwm_pkg::SPAN));
      end else begin
        phase_nxt[k] = PH_W'(s);
      end
    end
    torque1_nxt = (in_torque > scpwm_pkg::TORQUE_FULL) ? scpwm_pkg::TORQUE_FULL : in_torque;
  end

  // Stage 2: scale by the table depth and drop the 2^16 part of the span.
  always_comb begin
    logic [PH_W+DEPTH_W-1:0] p;
    for (int k = 0; k < NPH; k++) begin
      p = {{DEPTH_W{1'b0}}, phase_r[k]} * {{PH_W{1'b0}}, DEPTH_C};
      scaled_nxt[k] = Y_W'(p >> scpwm_pkg::ANGLE_W);
    end
  end

  // Stage 3: the remaining factor of three of the span.
  always_comb begin
    logic [Y_W+scpwm_pkg::RECIP3_W-1:0] p;
    for (int k = 0; k < NPH; k++) begin
      p = {{scpwm_pkg::RECIP3_W{1'b0}}, scaled_r[k]} * {{Y_W{1'b0}}, scpwm_pkg::RECIP3};
      idx_nxt[k] = IDX_W'(p >> scpwm_pkg::RECIP3_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_phase) begin
      phase_r   <= phase_nxt;
      torque1_r <= torque1_nxt;
    end
    if (ld.ld_scale) begin
      scaled_r  <= scaled_nxt;
      torque2_r <= torque1_r;
    end
    if (ld.ld_index) begin
      idx_r     <= idx_nxt;
      torque3_r <= torque2_r;
    end
  end

  assign idx_o    = idx_r;
  assign torque_o = torque3_r;

endmodule

>>> rtl/core/scpwm_lookup.sv
module scpwm_lookup #(
  parameter int PWM_BITS    = 10,
  parameter int TABLE_DEPTH = 244,
  localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic                                                   clk,
  input  scpwm_pkg::stage_ld_t                                   ld,
  input  logic [scpwm_pkg::NUM_PHASES-1:0][IDX_W-1:0]            idx_i,
  input  logic [scpwm_pkg::TORQUE_W-1:0]                         torque_i,
  output logic [scpwm_pkg::NUM_PHASES-1:0][scpwm_pkg::DUTY_W-1:0] duty_o
);

  localparam int NPH    = scpwm_pkg::NUM_PHASES;
  localparam int PROD_W = scpwm_pkg::TORQUE_W + PWM_BITS;
  localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] DEPTH_64    = 64'(TABLE_DEPTH);

  // Angle step of one table entry on the quarter turn, as quotient and remainder.
  localparam logic [63:0] STEP_HI  = HALF_PI_Q62 / DEPTH_64;
  localparam logic [63:0] STEP_REM = HALF_PI_Q62 % DEPTH_64;

  // Taylor series denominators (2n)(2n+1) for terms 1 to 20.
  localparam logic [63:0] TAYLOR_DIV [1:20] = '{
    64'd6,   64'd20,  64'd42,  64'd72,   64'd110,  64'd156,  64'd210,
    64'd272, 64'd342, 64'd420, 64'd506,  64'd600,  64'd702,  64'd812,
    64'd930, 64'd1056, 64'd1190, 64'd1332, 64'd1482, 64'd1640
  };

  typedef logic [PWM_BITS-1:0] tab_t [TABLE_DEPTH];

  // Q2.62 product, for operands below 2^63.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Taylor series of sin on the first quadrant, clipped to 1.0.
  function automatic logic [63:0] sine_q62(input logic [63:0] x);
    logic [63:0] x2, term, sum;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (logic [4:0] n = 5'd1; n <= 5'd20; n++) begin
      term = mul_q62(term, x2) / TAYLOR_DIV[n];
      if (n[0]) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return (sum > ONE_Q62) ? ONE_Q62 : sum;
  endfunction

  function automatic logic [63:0] quarter_sine(input logic [63:0] r);
    return sine_q62(STEP_HI * r + (STEP_REM * r) / DEPTH_64);
  endfunction

  // Offset sine table, worked out at elaboration.
  function automatic tab_t build_table();
    tab_t        tab;
    logic [63:0] q4, quad, r, mag, x;
    logic [127:0] p;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      q4   = 64'(4 * i);
      quad = q4 / DEPTH_64;
      r    = q4 % DEPTH_64;
      if (r == 64'd0) begin
        mag = quad[0] ? ONE_Q62 : 64'd0;
      end else if (quad[0]) begin
        mag = quarter_sine(DEPTH_64 - r);
      end else begin
        mag = quarter_sine(r);
      end
      x = (quad >= 64'd2) ? ONE_Q62 - mag : ONE_Q62 + mag;
      p = {64'd0, 64'((64'd1 << PWM_BITS) - 64'd1)} * {64'd0, x};
      tab[i] = PWM_BITS'(p >> 63);
    end
    return tab;
  endfunction

  localparam tab_t SINE_TAB = build_table();

  logic [NPH-1:0][PWM_BITS-1:0]          entry_r;
  logic [NPH-1:0][scpwm_pkg::DUTY_W-1:0] duty_nxt, duty_r;
  logic [scpwm_pkg::TORQUE_W-1:0]        torque4_r;

  always_comb begin
    logic [PROD_W-1:0] p;
    for (int k = 0; k < NPH; k++) begin
      p = {{PWM_BITS{1'b0}}, torque4_r} * {{scpwm_pkg::TORQUE_W{1'b0}}, entry_r[k]};
      duty_nxt[k] = scpwm_pkg::DUTY_W'(p >> scpwm_pkg::TORQUE_FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_read) begin
      for (int k = 0; k < NPH; k++) begin
        entry_r[k] <= SINE_TAB[idx_i[k]];
      end
      torque4_r <= torque_i;
    end
    if (ld.ld_duty) begin
      duty_r <= duty_nxt;
    end
  end

  assign duty_o = duty_r;

endmodule

>>> rtl/core/sine_commutation_pwm.sv
// Three-phase sine commutation: field angle and torque in, three PWM duties out.
// The five register stages each hold one item.
// Throughput: one item per cycle while the output is not stalled.
// Reset (rst_n low, synchronous) empties the pipeline; the table is constant logic.
// A stalled output holds its item and the stages behind it fill, then in_ready drops.
module sine_commutation_pwm #(
  parameter int PWM_BITS    = 10,
  parameter int TABLE_DEPTH = 244
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [scpwm_pkg::ANGLE_W-1:0]  in_field_angle,
  input  logic [scpwm_pkg::TORQUE_W-1:0] in_torque,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [scpwm_pkg::DUTY_W-1:0]   out_duty_a,
  output logic [scpwm_pkg::DUTY_W-1:0]   out_duty_b,
  output logic [scpwm_pkg::DUTY_W-1:0]   out_duty_c
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int NST   = scpwm_pkg::NUM_STAGES;

  // Stages: 1 phase angles and torque clamp, 2 depth scaling, 3 divide by
  // three into a table index, 4 table read, 5 torque scaling into the
  // output register.
  logic [NST-1:0] vld_r, vld_nxt;
  logic [NST:0]   rdy;
  scpwm_pkg::stage_ld_t ld;

  logic [scpwm_pkg::NUM_PHASES-1:0][IDX_W-1:0]            idx;
  logic [scpwm_pkg::TORQUE_W-1:0]                         torque3;
  logic [scpwm_pkg::NUM_PHASES-1:0][scpwm_pkg::DUTY_W-1:0] duty;

  // A stage takes a new item when it is empty or its item moves on in the
  // same cycle, so bubbles close up and a stall never drops an item.
  always_comb begin
    logic [NST-1:0] prev;
    rdy[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    prev = {vld_r[NST-2:0], in_valid};
    for (int i = 0; i < NST; i++) begin
      vld_nxt[i] = rdy[i] ? prev[i] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ld.ld_phase = rdy[0];
  assign ld.ld_scale = rdy[1];
  assign ld.ld_index = rdy[2];
  assign ld.ld_read  = rdy[3];
  assign ld.ld_duty  = rdy[4];

  scpwm_index #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_index (
    .clk           (clk),
    .ld            (ld),
    .in_field_angle(in_field_angle),
    .in_torque     (in_torque),
    .idx_o         (idx),
    .torque_o      (torque3)
  );

  scpwm_lookup #(
    .PWM_BITS   (PWM_BITS),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_lookup (
    .clk     (clk),
    .ld      (ld),
    .idx_i   (idx),
    .torque_i(torque3),
    .duty_o  (duty)
  );

  assign in_ready   = rdy[0];
  assign out_valid  = vld_r[NST-1];
  assign out_duty_a = duty[0];
  assign out_duty_b = duty[1];
  assign out_duty_c = duty[2];

endmodule

>>> rtl/core/scpwm_checker.sv
module scpwm_props (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [scpwm_pkg::TORQUE_W-1:0] in_torque,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [scpwm_pkg::DUTY_W-1:0]   out_duty_a,
  input logic [scpwm_pkg::DUTY_W-1:0]   out_duty_b,
  input logic [scpwm_pkg::DUTY_W-1:0]   out_duty_c
);

  // A draining output never holds back the input.
  a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input refused while output is taken");

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  // With the output always taken, a zero-torque item comes out of the last stage
  // with all duties zero.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_torque == '0) ##1 out_ready ##1 out_ready
      ##1 out_ready ##1 out_ready
    |=> out_valid && out_duty_a == '0 && out_duty_b == '0 && out_duty_c == '0)
    else $error("zero-torque item late or with nonzero duty");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready
    |=> out_valid && $stable(out_duty_a) && $stable(out_duty_b) && $stable(out_duty_c))
    else $error("stalled output item changed");

endmodule

bind sine_commutation_pwm scpwm_props u_scpwm_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_torque (in_torque),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_duty_a(out_duty_a),
  .out_duty_b(out_duty_b),
  .out_duty_c(out_duty_c)
);

>>> sim/scpwm_checker.sv
module scpwm_checker #(
  parameter int PWM_BITS    = 10,
  parameter int TABLE_DEPTH = 244
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [scpwm_pkg::ANGLE_W-1:0]  in_field_angle,
  input  logic [scpwm_pkg::TORQUE_W-1:0] in_torque,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [scpwm_pkg::DUTY_W-1:0]   out_duty_a,
  input  logic [scpwm_pkg::DUTY_W-1:0]   out_duty_b,
  input  logic [scpwm_pkg::DUTY_W-1:0]   out_duty_c,
  output int                             fail_count,
  output int                             pending_count,
  output int                             checked_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import scpwm_pkg::*;

  localparam bit [63:0] ONE_Q62     = 64'h4000000000000000;
  localparam bit [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam int        TURN        = 1 << ANGLE_W;

  typedef struct packed {
    logic [DUTY_W-1:0] a;
    logic [DUTY_W-1:0] b;
    logic [DUTY_W-1:0] c;
  } duty_set_t;

  duty_set_t   expected_duties[$];
  bit [31:0]   sine_lut[TABLE_DEPTH];

  // Product of two Q2.62 values, kept in Q2.62.
  function automatic bit [63:0] q62_mul(bit [63:0] x, bit [63:0] y);
    bit [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[125:62];
  endfunction

  // Truncated Taylor series on the first quadrant, clipped to 1.0.
  function automatic bit [63:0] q62_sine(bit [63:0] x);
    bit [63:0] x2;
    bit [63:0] term;
    bit [63:0] acc;
    x2   = q62_mul(x, x);
    term = x;
    acc  = x;
    for (int n = 1; n <= 20; n++) begin
      term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = (acc > term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    return (acc > ONE_Q62) ? ONE_Q62 : acc;
  endfunction

  // The offset sine table, built with the quadrant folded by symmetry so the
  // zero crossings and peaks come out exact.
  initial begin
    bit [63:0]  step_hi;
    bit [63:0]  step_rem;
    bit [63:0]  quad;
    bit [63:0]  r;
    bit [63:0]  mag;
    bit [63:0]  level;
    bit [127:0] scaled;
    step_hi  = HALF_PI_Q62 / TABLE_DEPTH;
    step_rem = HALF_PI_Q62 % TABLE_DEPTH;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      quad = (4 * i) / TABLE_DEPTH;
      r    = (4 * i) % TABLE_DEPTH;
      if (r == 0) begin
        mag = quad[0] ? ONE_Q62 : 64'd0;
      end else begin
        if (quad[0]) begin
          r = TABLE_DEPTH - r;
        end
        mag = q62_sine(step_hi * r + (step_rem * r) / TABLE_DEPTH);
      end
      level        = (quad >= 2) ? ONE_Q62 - mag : ONE_Q62 + mag;
      scaled       = {64'd0, 64'((1 << PWM_BITS) - 1)} * {64'd0, level};
      sine_lut[i]  = 32'(scaled >> 63);
    end
  end

  function automatic duty_set_t predict_duties(logic [ANGLE_W-1:0]  angle,
                                               logic [TORQUE_W-1:0] torque);
    bit [63:0]   scale;
    int unsigned pos;
    int unsigned idx;
    bit [63:0]   prod;
    logic [DUTY_W-1:0] duty[NUM_PHASES];
    scale = (torque > TORQUE_FULL) ? 64'(TORQUE_FULL) : 64'(torque);
    for (int k = 0; k < NUM_PHASES; k++) begin
      // Positions are in thirds of an angle unit so the offsets are exact.
      pos  = (3 * int'(angle) + k * TURN) % SPAN;
      idx  = (pos * TABLE_DEPTH) / SPAN;
      if (idx >= TABLE_DEPTH) begin
        idx = TABLE_DEPTH - 1;
      end
      prod    = (scale * 64'(sine_lut[idx])) >> TORQUE_FRAC;
      duty[k] = prod[DUTY_W-1:0];
    end
    return '{a: duty[0], b: duty[1], c: duty[2]};
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    duty_set_t want;
    if (!rst_n) begin
      expected_duties.delete();
      fail_count    = 0;
      checked_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_duties.push_back(predict_duties(in_field_angle, in_torque));
      end
      if (out_valid && out_ready) begin
        if (expected_duties.size() == 0) begin
          report_mismatch("result with no item outstanding, duty_a", out_duty_a, 0);
        end else begin
          want = expected_duties.pop_front();
          checked_count++;
          if (out_duty_a !== want.a) begin
            report_mismatch("duty_a", out_duty_a, want.a);
          end
          if (out_duty_b !== want.b) begin
            report_mismatch("duty_b", out_duty_b, want.b);
          end
          if (out_duty_c !== want.c) begin
            report_mismatch("duty_c", out_duty_c, want.c);
          end
        end
      end
    end
    pending_count = expected_duties.size();
  end

endmodule

>>> sim/tb_sine_commutation_pwm.sv
module tb_sine_commutation_pwm;
  timeunit 1ns;
  timeprecision 1ps;
  import scpwm_pkg::*;

  localparam int PWM_BITS        = 10;
  localparam int TABLE_DEPTH     = 244;
  localparam int ITEMS_PER_PHASE = 400;
  // Sized from the five-stage pipeline depth, for results still in flight.
  localparam int SETTLE_CYCLES   = 4 * NUM_STAGES;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [ANGLE_W-1:0]  in_field_angle = '0;
  logic [TORQUE_W-1:0] in_torque      = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [DUTY_W-1:0]   out_duty_a;
  logic [DUTY_W-1:0]   out_duty_b;
  logic [DUTY_W-1:0]   out_duty_c;

  int fail_count;
  int pending_count;
  int checked_count;

  // Flow-control knobs: percentage of cycles in which each side holds off.
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int saturated_sent = 0;

  // Directed items: angle extremes, the quarter-turn peaks and troughs, the
  // third-turn boundaries where phase B or C wraps past the end of the turn,
  // and torque at zero, full scale and in saturation.
  int unsigned dir_angle[21] = '{0, 65535, 16384, 32768, 49152, 21845, 21846,
                                 43690, 43691, 0, 65535, 16384, 16384, 16384,
                                 16384, 49152, 16'h5555, 16'hAAAA, 12345,
                                 16'h7FFF, 16'h8001};
  int unsigned dir_torque[21] = '{4096, 4096, 4096, 4096, 4096, 4096, 4096,
                                  4096, 4096, 0, 0, 1, 4095, 4097, 8191, 8191,
                                  13'h0AAA, 13'h1555, 2048, 4096, 4096};

  always #5 clk = ~clk;

  sine_commutation_pwm #(
    .PWM_BITS    (PWM_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_field_angle (in_field_angle),
    .in_torque      (in_torque),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_duty_a     (out_duty_a),
    .out_duty_b     (out_duty_b),
    .out_duty_c     (out_duty_c)
  );

  scpwm_checker #(
    .PWM_BITS    (PWM_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_field_angle (in_field_angle),
    .in_torque      (in_torque),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_duty_a     (out_duty_a),
    .out_duty_b     (out_duty_b),
    .out_duty_c     (out_duty_c),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  // The result side stalls at random; the stall rate follows the phase.
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Present one item at a falling edge and hold it until the block takes it.
  // The task returns at the falling edge after acceptance with in_valid still
  // high, so the next call either lowers it for a gap or replaces the payload,
  // never both in the same step.
  task automatic send_commutation(int unsigned angle, int unsigned torque);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_field_angle <= ANGLE_W'(angle);
    in_torque      <= TORQUE_W'(torque);
    do begin
      @(posedge clk);
    end while (!in_ready);
    items_sent++;
    if (torque > TORQUE_FULL) begin
      saturated_sent++;
    end
    @(negedge clk);
  endtask

  // Random item with a bias toward the interesting regions: angles right at a
  // table step, where an off-by-one in the index shows, and torque split
  // between the normal range, exact full scale, saturation and tiny values.
  task automatic send_random_commutation();
    int unsigned angle;
    int unsigned torque;
    int unsigned step;
    if ($urandom_range(0, 4) == 0) begin
      step  = $urandom_range(0, TABLE_DEPTH - 1);
      angle = ((step * 65536) / TABLE_DEPTH + $urandom_range(0, 2) - 1) & 16'hFFFF;
    end else begin
      angle = $urandom_range(0, 65535);
    end
    case ($urandom_range(0, 9))
      0: begin
        torque = TORQUE_FULL;
      end
      1: begin
        torque = $urandom_range(TORQUE_FULL + 1, (1 << TORQUE_W) - 1);
      end
      2: begin
        torque = $urandom_range(0, 15);
      end
      default: begin
        torque = $urandom_range(0, TORQUE_FULL);
      end
    endcase
    send_commutation(angle, torque);
  endtask

  // The sender holds off completely until every outstanding result is back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    // Synchronous reset, held low from the start and released at a falling edge.
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase one: sender gaps 30%, receiver stalls 49%, directed items first.
    send_gap_pct   = 30;
    recv_stall_pct = 49;
    foreach (dir_angle[i]) begin
      send_commutation(dir_angle[i], dir_torque[i]);
    end
    repeat (ITEMS_PER_PHASE) send_random_commutation();
    hold_until_drained();

    // Phase two: the rates swap sides, so backpressure is lighter.
    send_gap_pct   = 49;
    recv_stall_pct = 30;
    repeat (ITEMS_PER_PHASE) send_random_commutation();
    hold_until_drained();

    // Phase three: both sides run flat out, one item per cycle.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (ITEMS_PER_PHASE) send_random_commutation();
    hold_until_drained();

    // Give any stray result a chance to show up after the last expected one.
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d commutation items (%0d with saturated torque), %0d results checked",
             items_sent, saturated_sent, checked_count);
    $display("Flow control: mixed gaps and stalls both ways, then back-to-back streaming");
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about 1200 items.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still outstanding", pending_count);
    $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/scpwm_pkg.sv
rtl/core/scpwm_index.sv
rtl/core/scpwm_lookup.sv
rtl/core/sine_commutation_pwm.sv
rtl/core/scpwm_checker.sv
sim/scpwm_checker.sv
sim/tb_sine_commutation_pwm.sv
